### rtl/aoc_pkg.sv
// Shared constants for the accelerometer offset calibrator.
// Field widths, axis count and default calibration lengths; no dependencies.
package aoc_pkg;

  localparam int unsigned NumAxes = 3;

  // Raw sample and corrected result widths (two's complement)
  localparam int unsigned SampleW = 16;
  localparam int unsigned CorrW   = 17;

  // Default calibration lengths, in samples
  localparam int unsigned SettleCountDef = 19;
  localparam int unsigned AvgCountDef    = 100;

endpackage

### rtl/accel_offset_calibrator.sv
// Three-axis accelerometer zero-offset calibration and correction.
// Depends on aoc_pkg for widths and default calibration lengths.
//
// Usage: samples arrive on the input channel (in_valid_i / in_stall_o), results
// leave on the output channel (out_valid_o / out_stall_i); a transfer happens at
// a clock edge with valid high and stall low.
// After reset the block calibrates: the first SETTLE_COUNT samples are dropped,
// the next AVG_COUNT are summed per axis, and the sample after those fixes each
// offset to its sum / AVG_COUNT (truncated toward zero) and is dropped too.
// Calibration samples give no result. From then on every sample gives one
// result per axis: sample minus offset, read as g with 8 fraction bits.
// Results are registered, in the result register or the skid register.
// Throughput: one sample per cycle while in_stall_o is low. The offset
// division is a reciprocal multiply done in the transfer cycle of the closing
// sample, so the input is not stalled there either.
// Stall: a two-entry output stage (result register plus skid register) takes
// a sample while a result waits; in_stall_o rises only once both are full.
// Reset clears the control state and restarts calibration.
module accel_offset_calibrator
  import aoc_pkg::*;
#(
  parameter int unsigned SETTLE_COUNT = SettleCountDef,
  parameter int unsigned AVG_COUNT    = AvgCountDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_x_i,
  input  logic signed [SampleW-1:0] sample_y_i,
  input  logic signed [SampleW-1:0] sample_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [CorrW-1:0]   corrected_x_o,
  output logic signed [CorrW-1:0]   corrected_y_o,
  output logic signed [CorrW-1:0]   corrected_z_o
);

  localparam int unsigned PhaseW = $clog2(SETTLE_COUNT + AVG_COUNT + 1);
  localparam int unsigned DivL   = $clog2(AVG_COUNT);
  // Sum holds up to AVG_COUNT * 2^15 in magnitude
  localparam int unsigned SumW   = SampleW + DivL;
  localparam int unsigned DivK   = SumW + DivL;
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam int unsigned QuotW  = SampleW + 1;
  localparam longint unsigned RecipL =
    ((64'd1 << DivK) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
  localparam logic [RecipW-1:0] Recip   = RecipW'(RecipL);
  localparam logic [PhaseW-1:0] SettleEnd = PhaseW'(SETTLE_COUNT);
  localparam logic [PhaseW-1:0] AvgEnd    = PhaseW'(SETTLE_COUNT + AVG_COUNT);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CorrW-1:0]   corr_t;
  typedef logic signed [SumW-1:0]    sum_t;

  // Handshake
  logic in_acc, out_take, produce;

  // Calibration state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              calib_q, calib_d;
  sum_t              sum_q [NumAxes];
  sum_t              sum_d [NumAxes];
  logic [QuotW-1:0]  quot_q [NumAxes];
  logic [QuotW-1:0]  quot_d [NumAxes];
  logic              neg_q [NumAxes];
  logic              neg_d [NumAxes];

  // Output stage
  logic  out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  corr_t out_q [NumAxes];
  corr_t out_d [NumAxes];
  corr_t skid_q [NumAxes];
  corr_t skid_d [NumAxes];

  sample_t          sample [NumAxes];
  corr_t            corr [NumAxes];
  logic [SumW-1:0]  mag [NumAxes];
  logic [ProdW-1:0] prod [NumAxes];

  assign sample[0] = sample_x_i;
  assign sample[1] = sample_y_i;
  assign sample[2] = sample_z_i;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;
  assign produce    = in_acc & calib_q;

  // Per-axis datapath: correction, and quotient by reciprocal multiply
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      corr[a] = neg_q[a] ? (CorrW'(sample[a]) + CorrW'(quot_q[a]))
                         : (CorrW'(sample[a]) - CorrW'(quot_q[a]));
      mag[a]  = sum_q[a][SumW-1] ? (-sum_q[a]) : sum_q[a];
      prod[a] = ProdW'(mag[a]) * ProdW'(Recip);
    end
  end

  // Calibration sequence
  always_comb begin
    phase_d = phase_q;
    calib_d = calib_q;
    for (int a = 0; a < NumAxes; a++) begin
      sum_d[a]  = sum_q[a];
      quot_d[a] = quot_q[a];
      neg_d[a]  = neg_q[a];
    end
    if (in_acc && !calib_q) begin
      if (phase_q < SettleEnd) begin
        phase_d = phase_q + PhaseW'(1);
      end else if (phase_q < AvgEnd) begin
        phase_d = phase_q + PhaseW'(1);
        for (int a = 0; a < NumAxes; a++) begin
          sum_d[a] = sum_q[a] + SumW'(sample[a]);
        end
      end else begin
        // Closing sample: fix the offsets, drop the sample
        phase_d = '0;
        calib_d = 1'b1;
        for (int a = 0; a < NumAxes; a++) begin
          quot_d[a] = prod[a][DivK +: QuotW];
          neg_d[a]  = sum_q[a][SumW-1];
        end
      end
    end
  end

  // Result register with skid register behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    for (int a = 0; a < NumAxes; a++) begin
      out_d[a]  = out_q[a];
      skid_d[a] = skid_q[a];
    end
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
        for (int a = 0; a < NumAxes; a++) out_d[a] = skid_q[a];
      end else if (produce) begin
        out_valid_d = 1'b1;
        for (int a = 0; a < NumAxes; a++) out_d[a] = corr[a];
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (produce) begin
      // Result register held: park the new result
      skid_valid_d = 1'b1;
      for (int a = 0; a < NumAxes; a++) skid_d[a] = corr[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= '0;
      calib_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      for (int a = 0; a < NumAxes; a++) sum_q[a] <= '0;
    end else begin
      phase_q      <= phase_d;
      calib_q      <= calib_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      for (int a = 0; a < NumAxes; a++) sum_q[a] <= sum_d[a];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NumAxes; a++) begin
      quot_q[a] <= quot_d[a];
      neg_q[a]  <= neg_d[a];
      out_q[a]  <= out_d[a];
      skid_q[a] <= skid_d[a];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign corrected_x_o = out_q[0];
  assign corrected_y_o = out_q[1];
  assign corrected_z_o = out_q[2];

`ifndef SYNTHESIS
  // Skid register fills only behind a held result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register empty");

  // No result before calibration completes
  a_no_result_uncal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> calib_q)
    else $error("result presented before calibration");

  // Phase count stays within the calibration sequence
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= AvgEnd)
    else $error("phase count beyond calibration sequence");

  // Calibration is kept until reset
  a_calib_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    calib_q |=> calib_q)
    else $error("calibration lost");

  // Offsets are frozen once calibrated
  a_offset_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    calib_q |=> ($stable(quot_q[0]) && $stable(quot_q[1]) && $stable(quot_q[2])))
    else $error("offset changed after calibration");
`endif

endmodule
